### hw/rtl/nsp_pkg.sv
// Package: shared types, constants and helpers of the NMEA sentence parser.
`timescale 1ns / 1ps
package nsp_pkg;

  localparam int MaxLineDefault = 256;
  localparam int LimitW         = 9;
  localparam int NumSlots       = 3;
  localparam int AddrW          = 4;

  localparam logic [7:0] ChrStart = 8'h24;  // '$'
  localparam logic [7:0] ChrStar  = 8'h2A;  // '*'
  localparam logic [7:0] ChrComma = 8'h2C;  // ','
  localparam logic [7:0] ChrCr    = 8'h0D;
  localparam logic [7:0] ChrLf    = 8'h0A;

  typedef enum logic [1:0] {
    KIND_DATA    = 2'd0,
    KIND_FIELD   = 2'd1,
    KIND_VERDICT = 2'd2,
    KIND_LINE    = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    REG_MODE  = 2'd0,
    REG_START = 2'd1,
    REG_END   = 2'd2,
    REG_LIMIT = 2'd3
  } reg_e;

  typedef struct packed {
    logic              nmea_mode;
    logic [7:0]        start_byte;
    logic [7:0]        end_byte;
    logic [LimitW-1:0] line_limit;
  } cfg_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data_byte;
    logic [7:0] field_index;
    logic       checksum_ok;
    logic       last;
  } res_t;

  typedef struct packed {
    res_t [NumSlots-1:0] slot;
    logic [1:0]          n;
  } bundle_t;

  typedef struct packed {
    logic [7:0] running_xor;
    logic [7:0] field_number;
    logic       field_has_bytes;
    logic       in_checksum_part;
    logic       after_line_break;
    logic [1:0] hex_digit_count;
    logic [7:0] received_sum;
    logic       hex_valid;
    logic       header_ok;
  } dec_t;

  localparam dec_t DecClear = '{
    running_xor: 8'd0, field_number: 8'd0, field_has_bytes: 1'b0,
    in_checksum_part: 1'b0, after_line_break: 1'b0, hex_digit_count: 2'd0,
    received_sum: 8'd0, hex_valid: 1'b1, header_ok: 1'b0
  };

  function automatic logic is_hex(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
           (c >= 8'h41 && c <= 8'h46);
  endfunction

  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [7:0] v;
    v = 8'd0;
    if (c >= 8'h30 && c <= 8'h39) v = c - 8'h30;
    else if (c >= 8'h61 && c <= 8'h66) v = c - 8'h57;
    else if (c >= 8'h41 && c <= 8'h46) v = c - 8'h37;
    return v[3:0];
  endfunction

endpackage

### hw/rtl/nsp_cfg.sv
// APB register bank of the NMEA sentence parser.
`timescale 1ns / 1ps
module nsp_cfg (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [nsp_pkg::AddrW-1:0]  paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output nsp_pkg::cfg_t              cfg_o
);
  import nsp_pkg::*;

  cfg_t cfg_q, cfg_d;
  reg_e sel;

  assign sel    = reg_e'(paddr[3:2]);
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  // Update the addressed register on the access beat
  always_comb begin
    cfg_d = cfg_q;
    if (psel && penable && pwrite) begin
      case (sel)
        REG_MODE:  cfg_d.nmea_mode  = pwdata[0];
        REG_START: cfg_d.start_byte = pwdata[7:0];
        REG_END:   cfg_d.end_byte   = pwdata[7:0];
        REG_LIMIT: cfg_d.line_limit = pwdata[LimitW-1:0];
        default:   cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.nmea_mode  <= 1'b1;
      cfg_q.start_byte <= ChrStart;
      cfg_q.end_byte   <= 8'd10;
      cfg_q.line_limit <= LimitW'(83);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read back
  always_comb begin
    case (sel)
      REG_MODE:  prdata = {31'd0, cfg_q.nmea_mode};
      REG_START: prdata = {24'd0, cfg_q.start_byte};
      REG_END:   prdata = {24'd0, cfg_q.end_byte};
      REG_LIMIT: prdata = {{(32-LimitW){1'b0}}, cfg_q.line_limit};
      default:   prdata = 32'd0;
    endcase
  end

endmodule

### hw/rtl/nsp_core.sv
// Line framing and sentence decode: state registers and per-byte result bundle.
`timescale 1ns / 1ps
module nsp_core #(
  parameter int MAX_LINE = nsp_pkg::MaxLineDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  nsp_pkg::cfg_t    cfg_i,
  input  logic             accept_i,
  input  logic [7:0]       rx_byte_i,
  output nsp_pkg::bundle_t bundle_o
);
  import nsp_pkg::*;

  localparam int CntW = $clog2(MAX_LINE);

  logic [CntW-1:0]   cnt_q, cnt_d, cnt_inc;
  dec_t              st_q, st_d, w;
  logic [LimitW-1:0] lim, lim_m1;
  logic              first, drop, closing, hex_ok;
  logic [7:0]        chk;
  logic [1:0]        n;
  bundle_t           bun;

  // Clamp the line limit into its legal range
  always_comb begin
    if (cfg_i.line_limit < LimitW'(2)) lim = LimitW'(2);
    else if (cfg_i.line_limit > LimitW'(MAX_LINE)) lim = LimitW'(MAX_LINE);
    else lim = cfg_i.line_limit;
    lim_m1 = lim - LimitW'(1);
  end

  assign first   = (cnt_q == '0);
  assign drop    = cfg_i.nmea_mode && first && (rx_byte_i != cfg_i.start_byte);
  assign cnt_inc = cnt_q + CntW'(1);

  // Work out next state and the results of this byte
  always_comb begin
    w       = first ? DecClear : st_q;
    n       = 2'd0;
    bun     = '0;
    cnt_d   = cnt_inc;
    closing = 1'b0;
    hex_ok  = 1'b0;
    chk     = 8'd0;
    if (first) w.header_ok = cfg_i.nmea_mode;

    if (w.header_ok) begin
      if (!first && !w.after_line_break) begin
        if (rx_byte_i == ChrCr || rx_byte_i == ChrLf) begin
          w.after_line_break = 1'b1;
        end else if (w.in_checksum_part) begin
          if (w.hex_digit_count != 2'd3) w.hex_digit_count = w.hex_digit_count + 2'd1;
          if (w.hex_digit_count != 2'd3 && is_hex(rx_byte_i)) begin
            w.received_sum = {w.received_sum[3:0], hex_value(rx_byte_i)};
          end else begin
            w.hex_valid = 1'b0;
          end
        end else if (rx_byte_i == ChrStar || rx_byte_i == ChrComma) begin
          if (rx_byte_i == ChrComma) w.running_xor = w.running_xor ^ rx_byte_i;
          bun.slot[n] = '{kind: KIND_FIELD, data_byte: 8'd0,
                          field_index: w.field_number, checksum_ok: 1'b0, last: 1'b0};
          n = n + 2'd1;
          w.field_number    = w.field_number + 8'd1;
          w.field_has_bytes = 1'b0;
          if (rx_byte_i == ChrStar) w.in_checksum_part = 1'b1;
        end else begin
          w.running_xor     = w.running_xor ^ rx_byte_i;
          w.field_has_bytes = 1'b1;
          bun.slot[n] = '{kind: KIND_DATA, data_byte: rx_byte_i,
                          field_index: w.field_number, checksum_ok: 1'b0, last: 1'b0};
          n = n + 2'd1;
        end
      end
    end else begin
      bun.slot[n] = '{kind: KIND_DATA, data_byte: rx_byte_i,
                      field_index: 8'd0, checksum_ok: 1'b0, last: 1'b0};
      n = n + 2'd1;
    end

    // Close the line on the end byte or a full buffer
    closing = (LimitW'(cnt_inc) >= lim_m1) || (rx_byte_i == cfg_i.end_byte);
    if (closing) begin
      if (w.header_ok) begin
        if (w.in_checksum_part) begin
          if (w.hex_digit_count != 2'd0) begin
            hex_ok = w.hex_valid && (w.hex_digit_count == 2'd2);
            chk    = hex_ok ? w.received_sum : 8'd0;
            bun.slot[n] = '{kind: KIND_VERDICT, data_byte: 8'd0,
                            field_index: w.field_number,
                            checksum_ok: (w.running_xor == chk), last: 1'b0};
            n = n + 2'd1;
          end
        end else if (w.field_has_bytes) begin
          bun.slot[n] = '{kind: KIND_FIELD, data_byte: 8'd0,
                          field_index: w.field_number, checksum_ok: 1'b0, last: 1'b0};
          n = n + 2'd1;
        end
      end
      bun.slot[n] = '{kind: KIND_LINE, data_byte: 8'd0,
                      field_index: 8'd0, checksum_ok: 1'b0, last: 1'b0};
      n = n + 2'd1;
      cnt_d = '0;
      w     = DecClear;
    end

    if (n != 2'd0) bun.slot[n - 2'd1].last = 1'b1;
    bun.n = n;

    // Drop bytes outside a sentence with no effect
    st_d = w;
    if (drop) begin
      st_d  = st_q;
      cnt_d = cnt_q;
      bun.n = 2'd0;
    end
  end

  assign bundle_o = bun;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      st_q  <= DecClear;
    end else if (accept_i) begin
      cnt_q <= cnt_d;
      st_q  <= st_d;
    end
  end

endmodule

### hw/rtl/nsp_out.sv
// Result register: holds one byte's results and hands them out one beat at a time.
`timescale 1ns / 1ps
module nsp_out (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  nsp_pkg::bundle_t bundle_i,
  input  logic             out_ready_i,
  output logic             out_valid_o,
  output nsp_pkg::res_t    res_o,
  output logic             free_o
);
  import nsp_pkg::*;

  res_t [NumSlots-1:0] slot_q, slot_d;
  logic [1:0]          cnt_q, cnt_d;
  logic                pop;

  assign out_valid_o = (cnt_q != 2'd0);
  assign res_o       = slot_q[0];
  assign pop         = out_valid_o && out_ready_i;
  // Room for a new bundle once the held results drain this cycle
  assign free_o      = (cnt_q == 2'd0) || (cnt_q == 2'd1 && out_ready_i);

  // Load a fresh bundle or shift the held results down on each beat
  always_comb begin
    slot_d = slot_q;
    cnt_d  = cnt_q;
    if (load_i) begin
      slot_d = bundle_i.slot;
      cnt_d  = bundle_i.n;
    end else if (pop) begin
      slot_d[0] = slot_q[1];
      slot_d[1] = slot_q[2];
      cnt_d     = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

endmodule

### hw/rtl/nmea_sentence_parser.sv
// Top level of the NMEA sentence parser: registers, decode core and result register.
`timescale 1ns / 1ps
// Received bytes enter on the rx channel and leave as result beats (data byte,
// field end, checksum verdict, line end), one beat per cycle while out_ready_i is
// high. The result register holds every result of one byte and drains one per
// cycle while out_ready_i is high, so a byte that yields at most one result is
// taken every cycle, and a byte that yields k results (k up to 3, at a field or
// line close) holds the rx channel until they drain. rx_ready_o is high whenever
// the result register is empty or is handing out its final beat. Configuration is
// written over the APB port, by the user only while idle; the block does not check.
module nmea_sentence_parser #(
  parameter int MAX_LINE = nsp_pkg::MaxLineDefault
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [nsp_pkg::AddrW-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  input  logic                      rx_valid_i,
  output logic                      rx_ready_o,
  input  logic [7:0]                rx_byte_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [1:0]                kind_o,
  output logic [7:0]                data_byte_o,
  output logic [7:0]                field_index_o,
  output logic                      checksum_ok_o,
  output logic                      last_o
);
  import nsp_pkg::*;

  cfg_t    cfg;
  bundle_t bundle;
  res_t    res;
  logic    free, accept;

  nsp_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign rx_ready_o = free;
  assign accept     = rx_valid_i && free;

  nsp_core #(.MAX_LINE(MAX_LINE)) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .accept_i  (accept),
    .rx_byte_i (rx_byte_i),
    .bundle_o  (bundle)
  );

  nsp_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept && (bundle.n != 2'd0)),
    .bundle_i    (bundle),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .res_o       (res),
    .free_o      (free)
  );

  assign kind_o        = res.kind;
  assign data_byte_o   = res.data_byte;
  assign field_index_o = res.field_index;
  assign checksum_ok_o = res.checksum_ok;
  assign last_o        = res.last;

  // An empty result register always takes a byte
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> rx_ready_o)
    else $error("rx not ready with empty result register");

  // The final beat of a byte frees the result register in the same cycle
  a_ready_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_o && out_ready_i) |-> rx_ready_o)
    else $error("rx not ready while last beat drains");

  // A line end always closes the results of its byte
  a_line_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o == KIND_LINE) |-> last_o)
    else $error("line end not marked last");

  // Only data beats carry a character
  a_data_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o != KIND_DATA) |-> (data_byte_o == 8'd0))
    else $error("non-data beat carries a character");

endmodule
